### sv/cts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, codes and character tables of the text serializer.
// ----------------------------------------------------------------------------
package cts_pkg;

	typedef enum logic [3:0] {
		CMD_NULL   = 4'd0,
		CMD_BOOL   = 4'd1,
		CMD_INT    = 4'd2,
		CMD_UINT   = 4'd3,
		CMD_DEC    = 4'd4,
		CMD_BLOB   = 4'd5,
		CMD_STRING = 4'd6,
		CMD_LIST   = 4'd7,
		CMD_MAP    = 4'd8,
		CMD_IMAP   = 4'd9,
		CMD_META   = 4'd10,
		CMD_END    = 4'd11
	} cmd_t;

	typedef struct packed {
		logic [3:0]        cmd;
		logic [63:0]       value_bits;
		logic signed [7:0] dec_exponent;
		logic [7:0]        data_byte;
		logic              byte_valid;
		logic              first_piece;
		logic              last_piece;
		logic              hex_blob;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
	} out_item_t;

	typedef enum logic [1:0] {
		LK_LIST = 2'd0,
		LK_MAP  = 2'd1,
		LK_IMAP = 2'd2,
		LK_META = 2'd3
	} level_kind_t;

	// Per-level context kept in the level memory. The meta-pending flag lives
	// in flip-flops next to it.
	typedef struct packed {
		level_kind_t kind;
		logic        first;
		logic        even;
	} ctx_t;

	typedef enum logic [1:0] {
		SEP_NONE  = 2'd0,
		SEP_COMMA = 2'd1,
		SEP_COLON = 2'd2
	} sep_t;

	typedef enum logic [3:0] {
		LIT_NONE  = 4'd0,
		LIT_NULL  = 4'd1,
		LIT_TRUE  = 4'd2,
		LIT_FALSE = 4'd3,
		LIT_OLIST = 4'd4,
		LIT_OMAP  = 4'd5,
		LIT_OIMAP = 4'd6,
		LIT_OMETA = 4'd7,
		LIT_ELIDE = 4'd8,
		LIT_CLIST = 4'd9,
		LIT_CMAP  = 4'd10,
		LIT_CMETA = 4'd11,
		LIT_QSTR  = 4'd12,
		LIT_QHEX  = 4'd13,
		LIT_QBLOB = 4'd14
	} lit_t;

	typedef enum logic [1:0] {
		NUM_NONE = 2'd0,
		NUM_INT  = 2'd1,
		NUM_UINT = 2'd2,
		NUM_DEC  = 2'd3
	} num_t;

	// One classified transaction from the front end to the character engine.
	typedef struct packed {
		sep_t              sep;
		lit_t              lit;
		num_t              num;
		logic [63:0]       value_bits;
		logic signed [7:0] dec_exponent;
		logic [7:0]        data_byte;
		logic              byte_valid;
		logic              last_piece;
		logic              is_blob;
		logic              hex_blob;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE = 2'd0,
		F_PROC = 2'd1,
		F_WR2  = 2'd2
	} front_state_t;

	typedef enum logic [4:0] {
		B_IDLE  = 5'd0,
		B_SEP   = 5'd1,
		B_LIT   = 5'd2,
		B_CONV  = 5'd3,
		B_TRIM  = 5'd4,
		B_SIGN  = 5'd5,
		B_DIG1  = 5'd6,
		B_ZER1  = 5'd7,
		B_ZPRE  = 5'd8,
		B_DOT   = 5'd9,
		B_ZER2  = 5'd10,
		B_DIG2  = 5'd11,
		B_EXPE  = 5'd12,
		B_EXPS  = 5'd13,
		B_EXPD  = 5'd14,
		B_SUFX  = 5'd15,
		B_CONT  = 5'd16,
		B_CLOSE = 5'd17,
		B_DONE  = 5'd18
	} back_state_t;

	localparam int unsigned BCD_DIGITS = 20;
	localparam int unsigned VALUE_BITS = 64;

	typedef struct packed {
		logic [2:0]  n;
		logic [39:0] s;
	} lit_text_t;

	typedef struct packed {
		logic [1:0]  n;
		logic [23:0] s;
	} content_t;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		hex_char = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
	endfunction

	// Fixed text of every literal; characters are right aligned in s.
	function automatic lit_text_t lit_text(input lit_t l);
		lit_text_t r;
		r = '0;
		unique case (l)
			LIT_NULL:  begin r.n = 3'd4; r.s = 40'("null");  end
			LIT_TRUE:  begin r.n = 3'd4; r.s = 40'("true");  end
			LIT_FALSE: begin r.n = 3'd5; r.s = 40'("false"); end
			LIT_OLIST: begin r.n = 3'd1; r.s = 40'("[");     end
			LIT_OMAP:  begin r.n = 3'd1; r.s = 40'("{");     end
			LIT_OIMAP: begin r.n = 3'd2; r.s = 40'("i{");    end
			LIT_OMETA: begin r.n = 3'd1; r.s = 40'("<");     end
			LIT_ELIDE: begin r.n = 3'd3; r.s = 40'("...");   end
			LIT_CLIST: begin r.n = 3'd1; r.s = 40'("]");     end
			LIT_CMAP:  begin r.n = 3'd1; r.s = 40'("}");     end
			LIT_CMETA: begin r.n = 3'd1; r.s = 40'(">");     end
			LIT_QSTR:  begin r.n = 3'd1; r.s = 40'h22;       end
			LIT_QHEX:  begin r.n = 3'd2; r.s = {24'h0, 8'h78, 8'h22}; end
			LIT_QBLOB: begin r.n = 3'd2; r.s = {24'h0, 8'h62, 8'h22}; end
			default:   begin r.n = 3'd0; r.s = '0; end
		endcase
		return r;
	endfunction

	// Characters written for one content byte of a string or blob.
	function automatic content_t content_chars(input logic [7:0] b, input logic blob,
			input logic hex);
		content_t   r;
		logic [7:0] e;
		logic       esc;
		esc = 1'b1;
		unique case (b)
			8'h5c:   e = 8'h5c;
			8'h00:   e = 8'h30;
			8'h07:   e = 8'h61;
			8'h08:   e = 8'h62;
			8'h09:   e = 8'h74;
			8'h0a:   e = 8'h6e;
			8'h0b:   e = 8'h76;
			8'h0c:   e = 8'h66;
			8'h0d:   e = 8'h72;
			8'h22:   e = 8'h22;
			default: begin esc = 1'b0; e = b; end
		endcase
		if (blob && hex) begin
			r.n = 2'd2;
			r.s = {8'h00, hex_char(b[7:4]), hex_char(b[3:0])};
		end else if (esc) begin
			r.n = 2'd2;
			r.s = {8'h00, 8'h5c, e};
		end else if (blob && (b < 8'd32 || b >= 8'd127)) begin
			r.n = 2'd3;
			r.s = {8'h5c, hex_char(b[7:4]), hex_char(b[3:0])};
		end else begin
			r.n = 2'd1;
			r.s = {16'h0000, b};
		end
		return r;
	endfunction

	// Decimal digits of an exponent magnitude: {hundreds, tens, ones}.
	function automatic logic [11:0] exp_digits(input logic [7:0] ex);
		logic [3:0]  h;
		logic [7:0]  r;
		logic [15:0] prod;
		logic [3:0]  t;
		logic [7:0]  o;
		h = (ex >= 8'd200) ? 4'd2 : ((ex >= 8'd100) ? 4'd1 : 4'd0);
		r = ex - 8'({4'h0, h} * 8'd100);
		prod = {8'h00, r} * 16'd205;
		t = prod[14:11];
		o = r - 8'({4'h0, t} * 8'd10);
		return {h, t, o[3:0]};
	endfunction

endpackage

### sv/cts_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_job_fifo
// Two-entry queue of classified transactions between front end and engine.
// ----------------------------------------------------------------------------
module cts_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  cts_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output cts_pkg::job_t rd_data,
	output logic          empty
);

	cts_pkg::job_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({wr_en && !full, rd_en && !empty})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### sv/cts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_front
// Accepts items, tracks the nesting stack and classifies each item into one
// transaction for the character engine.
// ----------------------------------------------------------------------------
module cts_front #(
	parameter int MAX_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  cts_pkg::in_item_t item,
	input  logic              cfg_wen,
	input  logic [4:0]        cfg_wdata,
	output logic              q_push,
	output cts_pkg::job_t     q_data,
	input  logic              q_full
);

	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	cts_pkg::front_state_t fst_q, fst_d;
	cts_pkg::in_item_t     item_s1;
	cts_pkg::ctx_t         rd_s1;
	cts_pkg::ctx_t         ctx_mem [MAX_DEPTH];
	logic [7:0]            depth_q, depth_d;
	logic [4:0]            limit_q;
	logic [MAX_DEPTH-1:0]  meta_q;
	logic [AW-1:0]         wr2_addr_q;
	cts_pkg::ctx_t         wr2_data_q;

	logic [7:0]    lim;
	logic [7:0]    dm1;
	logic [AW-1:0] a_dm1, a_dm2, a_d;
	logic          accept, advance;
	logic          meta_top, is_piece;
	cts_pkg::job_t job;
	logic          job_v;
	logic          mem_we;
	cts_pkg::ctx_t mem_wd;
	logic          open_wr;
	cts_pkg::ctx_t open_wd;
	logic          meta_set, meta_clr_top, meta_clr_new;

	assign lim = (limit_q == 5'd0) ? 8'd1 :
		(({3'b000, limit_q} > 8'(MAX_DEPTH)) ? 8'(MAX_DEPTH) : {3'b000, limit_q});
	assign dm1      = depth_q - 8'd1;
	assign a_dm1    = AW'(dm1);
	assign a_dm2    = AW'(depth_q - 8'd2);
	assign a_d      = AW'(depth_q);
	assign meta_top = meta_q[a_dm1];
	assign is_piece = (item_s1.cmd == cts_pkg::CMD_BLOB) ||
		(item_s1.cmd == cts_pkg::CMD_STRING);

	// Classification of the captured item against the level read at accept.
	always_comb begin
		job              = '0;
		job.value_bits   = item_s1.value_bits;
		job.dec_exponent = item_s1.dec_exponent;
		job.data_byte    = item_s1.data_byte;
		job.hex_blob     = item_s1.hex_blob;
		job_v        = 1'b0;
		mem_we       = 1'b0;
		mem_wd       = rd_s1;
		open_wr      = 1'b0;
		open_wd      = '0;
		meta_set     = 1'b0;
		meta_clr_top = 1'b0;
		meta_clr_new = 1'b0;
		depth_d      = depth_q;
		if (item_s1.cmd == cts_pkg::CMD_END) begin
			if (depth_q != 8'd0) begin
				depth_d = dm1;
				if (dm1 < lim) begin
					job_v = 1'b1;
					unique case (rd_s1.kind)
						cts_pkg::LK_LIST: job.lit = cts_pkg::LIT_CLIST;
						cts_pkg::LK_MAP,
						cts_pkg::LK_IMAP: job.lit = cts_pkg::LIT_CMAP;
						default: begin
							job.lit  = cts_pkg::LIT_CMETA;
							meta_set = (dm1 != 8'd0);
						end
					endcase
				end
			end
		end else if (item_s1.cmd < cts_pkg::CMD_END && depth_q <= lim) begin
			if (depth_q != 8'd0 && !(is_piece && !item_s1.first_piece)) begin
				if (!meta_top) begin
					if (rd_s1.kind == cts_pkg::LK_LIST || rd_s1.even) begin
						job.sep = rd_s1.first ? cts_pkg::SEP_NONE : cts_pkg::SEP_COMMA;
					end else begin
						job.sep = cts_pkg::SEP_COLON;
					end
					mem_we       = 1'b1;
					mem_wd.first = 1'b0;
					mem_wd.even  = ~rd_s1.even;
				end else begin
					meta_clr_top = 1'b1;
				end
			end
			unique case (item_s1.cmd)
				cts_pkg::CMD_NULL: job.lit = cts_pkg::LIT_NULL;
				cts_pkg::CMD_BOOL: job.lit = item_s1.value_bits[0] ?
					cts_pkg::LIT_TRUE : cts_pkg::LIT_FALSE;
				cts_pkg::CMD_INT:  job.num = cts_pkg::NUM_INT;
				cts_pkg::CMD_UINT: job.num = cts_pkg::NUM_UINT;
				cts_pkg::CMD_DEC:  job.num = cts_pkg::NUM_DEC;
				cts_pkg::CMD_BLOB, cts_pkg::CMD_STRING: begin
					job.is_blob    = (item_s1.cmd == cts_pkg::CMD_BLOB);
					job.byte_valid = item_s1.byte_valid;
					job.last_piece = item_s1.last_piece;
					if (item_s1.first_piece) begin
						if (item_s1.cmd == cts_pkg::CMD_STRING) begin
							job.lit = cts_pkg::LIT_QSTR;
						end else begin
							job.lit = item_s1.hex_blob ? cts_pkg::LIT_QHEX : cts_pkg::LIT_QBLOB;
						end
					end
				end
				default: begin
					if (depth_q < lim) begin
						open_wr       = 1'b1;
						open_wd.kind  = cts_pkg::level_kind_t'(2'(item_s1.cmd[1:0] + 2'd1));
						open_wd.first = 1'b1;
						open_wd.even  = 1'b1;
						meta_clr_new  = 1'b1;
						unique case (open_wd.kind)
							cts_pkg::LK_LIST: job.lit = cts_pkg::LIT_OLIST;
							cts_pkg::LK_MAP:  job.lit = cts_pkg::LIT_OMAP;
							cts_pkg::LK_IMAP: job.lit = cts_pkg::LIT_OIMAP;
							default:          job.lit = cts_pkg::LIT_OMETA;
						endcase
					end else begin
						job.lit = cts_pkg::LIT_ELIDE;
					end
					if (depth_q != 8'hff) begin
						depth_d = depth_q + 8'd1;
					end
				end
			endcase
			job_v = (job.sep != cts_pkg::SEP_NONE) || (job.lit != cts_pkg::LIT_NONE) ||
				(job.num != cts_pkg::NUM_NONE) || job.byte_valid || job.last_piece;
		end else if (item_s1.cmd >= cts_pkg::CMD_LIST && item_s1.cmd <= cts_pkg::CMD_META &&
				depth_q != 8'hff) begin
			// Inside an elided level only the depth count moves.
			depth_d = depth_q + 8'd1;
		end
	end

	assign accept  = push && !full;
	assign advance = (fst_q == cts_pkg::F_PROC) && (!job_v || !q_full);

	always_comb begin
		fst_d = fst_q;
		unique case (fst_q)
			cts_pkg::F_IDLE: if (accept) fst_d = cts_pkg::F_PROC;
			cts_pkg::F_PROC: if (advance) fst_d = open_wr ? cts_pkg::F_WR2 : cts_pkg::F_IDLE;
			cts_pkg::F_WR2:  fst_d = cts_pkg::F_IDLE;
			default:         fst_d = cts_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		full   = (fst_q != cts_pkg::F_IDLE);
		q_push = advance && job_v;
		q_data = job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q   <= cts_pkg::F_IDLE;
			depth_q <= 8'd0;
			limit_q <= 5'd16;
			meta_q  <= '0;
		end else begin
			fst_q <= fst_d;
			if (cfg_wen) begin
				limit_q <= cfg_wdata;
			end
			if (advance) begin
				depth_q <= depth_d;
				if (meta_clr_top) meta_q[a_dm1] <= 1'b0;
				if (meta_set)     meta_q[a_dm2] <= 1'b1;
				if (meta_clr_new) meta_q[a_d]   <= 1'b0;
			end
		end
	end

	// Level memory: one read at accept, one write per cycle. An opener's own
	// entry is written in the cycle after the separator update of its parent.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			rd_s1   <= ctx_mem[a_dm1];
		end
		if (advance && mem_we) begin
			ctx_mem[a_dm1] <= mem_wd;
		end else if (fst_q == cts_pkg::F_WR2) begin
			ctx_mem[wr2_addr_q] <= wr2_data_q;
		end
		if (advance) begin
			wr2_addr_q <= a_d;
			wr2_data_q <= open_wd;
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("transaction pushed into a full queue");
	a_accept_starts_proc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (fst_q == cts_pkg::F_PROC)) else $error("accepted item not processed");
	a_depth_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(depth_q)) else $error("nesting depth moved without an item");

endmodule

### sv/cts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_back
// Character engine: turns one queued transaction into its characters,
// converting numbers to decimal with a serial binary-to-BCD unit.
// ----------------------------------------------------------------------------
module cts_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               q_pop,
	input  cts_pkg::job_t      q_data,
	output logic               empty,
	input  logic               pop,
	output cts_pkg::out_item_t result
);

	cts_pkg::back_state_t st_q, st_d, succ;
	logic [6:0]           pos_q;
	cts_pkg::job_t        job_q;
	logic [63:0]          mag_q;
	logic                 neg_q;
	logic [79:0]          bcd_q;
	logic [4:0]           len_q;
	logic                 hold_v_q;
	logic [7:0]           hold_c_q;
	logic                 out_v_q;
	cts_pkg::out_item_t   out_q;

	logic        fixed, expo, e_neg;
	logic [7:0]  e_u, ex, lenx, pos8;
	logic [7:0]  n_dig1, n_zer1, n_zer2, n_dig2, n_exp;
	logic        zpre;
	logic [11:0] exd;
	logic [1:0]  exk;
	cts_pkg::lit_text_t lt;
	cts_pkg::content_t  ct;
	logic [7:0]  need;
	logic [7:0]  ch;
	logic        counted;
	logic        emit_en, go, out_free, push_out;
	logic [79:0] bcd_adj;
	logic        trim_more;
	logic        in_neg;

	// Field counts of the decimal layouts, from the trimmed digit count.
	always_comb begin
		e_u    = job_q.dec_exponent;
		e_neg  = job_q.dec_exponent[7];
		ex     = e_neg ? (~e_u + 8'd1) : e_u;
		fixed  = (job_q.num == cts_pkg::NUM_DEC) &&
			(job_q.dec_exponent <= 8'sd6) && (job_q.dec_exponent >= -8'sd9);
		expo   = (job_q.num == cts_pkg::NUM_DEC) && !fixed;
		lenx   = {3'b000, len_q};
		n_dig1 = (fixed && e_neg) ? ((lenx > ex) ? (lenx - ex) : 8'd0) : lenx;
		n_zer1 = (fixed && !e_neg) ? e_u : 8'd0;
		zpre   = fixed && e_neg && (lenx <= ex);
		n_zer2 = (fixed && e_neg && ex > lenx) ? (ex - lenx) : 8'd0;
		n_dig2 = (fixed && e_neg) ? ((lenx < ex) ? lenx : ex) : 8'd0;
		n_exp  = (ex >= 8'd100) ? 8'd3 : ((ex >= 8'd10) ? 8'd2 : 8'd1);
		exd    = cts_pkg::exp_digits(ex);
		pos8   = {1'b0, pos_q};
		exk    = 2'(pos_q[1:0] + 2'(8'd3 - n_exp));
		lt     = cts_pkg::lit_text(job_q.lit);
		ct     = cts_pkg::content_chars(job_q.data_byte, job_q.is_blob, job_q.hex_blob);
	end

	// Characters needed in the current state and the one at pos_q.
	always_comb begin
		need    = 8'd0;
		ch      = 8'h30;
		counted = 1'b1;
		unique case (st_q)
			cts_pkg::B_SEP: begin
				need = (job_q.sep != cts_pkg::SEP_NONE) ? 8'd1 : 8'd0;
				ch   = (job_q.sep == cts_pkg::SEP_COLON) ? 8'h3a : 8'h2c;
			end
			cts_pkg::B_LIT: begin
				need = {5'b00000, lt.n};
				ch   = 8'(lt.s >> {(lt.n - 3'd1 - pos_q[2:0]), 3'b000});
			end
			cts_pkg::B_SIGN: begin
				need = neg_q ? 8'd1 : 8'd0;
				ch   = 8'h2d;
			end
			cts_pkg::B_DIG1: begin
				need = n_dig1;
				ch   = 8'h30 + {4'h0, bcd_q[79:76]};
			end
			cts_pkg::B_ZER1: need = n_zer1;
			cts_pkg::B_ZPRE: need = zpre ? 8'd1 : 8'd0;
			cts_pkg::B_DOT: begin
				need = fixed ? 8'd1 : 8'd0;
				ch   = 8'h2e;
			end
			cts_pkg::B_ZER2: need = n_zer2;
			cts_pkg::B_DIG2: begin
				need = n_dig2;
				ch   = 8'h30 + {4'h0, bcd_q[79:76]};
			end
			cts_pkg::B_EXPE: begin
				need = expo ? 8'd1 : 8'd0;
				ch   = 8'h65;
			end
			cts_pkg::B_EXPS: begin
				need = (expo && e_neg) ? 8'd1 : 8'd0;
				ch   = 8'h2d;
			end
			cts_pkg::B_EXPD: begin
				need = expo ? n_exp : 8'd0;
				ch   = 8'h30 + {4'h0, 4'(exd >> {2'(2'd2 - exk), 2'b00})};
			end
			cts_pkg::B_SUFX: begin
				need = (job_q.num == cts_pkg::NUM_UINT) ? 8'd1 : 8'd0;
				ch   = 8'h75;
			end
			cts_pkg::B_CONT: begin
				need = job_q.byte_valid ? {6'b000000, ct.n} : 8'd0;
				ch   = 8'(ct.s >> {(ct.n - 2'd1 - pos_q[1:0]), 3'b000});
			end
			cts_pkg::B_CLOSE: begin
				need = job_q.last_piece ? 8'd1 : 8'd0;
				ch   = 8'h22;
			end
			default: counted = 1'b0;
		endcase
	end

	assign trim_more = (len_q > 5'd1) && (bcd_q[79:76] == 4'h0);
	assign out_free  = !out_v_q || pop;

	// Outputs of the sequencer.
	always_comb begin
		emit_en  = counted && (pos8 < need);
		go       = out_free || !((emit_en && hold_v_q) || st_q == cts_pkg::B_DONE);
		push_out = go && ((emit_en && hold_v_q) || st_q == cts_pkg::B_DONE);
		q_pop    = go && (st_q == cts_pkg::B_IDLE) && !q_empty;
		empty    = !out_v_q;
		result   = out_q;
	end

	// Next state.
	always_comb begin
		unique case (st_q)
			cts_pkg::B_SEP:   succ = cts_pkg::B_LIT;
			cts_pkg::B_LIT:   succ = (job_q.num != cts_pkg::NUM_NONE) ?
				cts_pkg::B_CONV : cts_pkg::B_CONT;
			cts_pkg::B_SIGN:  succ = cts_pkg::B_DIG1;
			cts_pkg::B_DIG1:  succ = cts_pkg::B_ZER1;
			cts_pkg::B_ZER1:  succ = cts_pkg::B_ZPRE;
			cts_pkg::B_ZPRE:  succ = cts_pkg::B_DOT;
			cts_pkg::B_DOT:   succ = cts_pkg::B_ZER2;
			cts_pkg::B_ZER2:  succ = cts_pkg::B_DIG2;
			cts_pkg::B_DIG2:  succ = cts_pkg::B_EXPE;
			cts_pkg::B_EXPE:  succ = cts_pkg::B_EXPS;
			cts_pkg::B_EXPS:  succ = cts_pkg::B_EXPD;
			cts_pkg::B_EXPD:  succ = cts_pkg::B_SUFX;
			cts_pkg::B_SUFX:  succ = cts_pkg::B_CONT;
			cts_pkg::B_CONT:  succ = cts_pkg::B_CLOSE;
			default:          succ = cts_pkg::B_DONE;
		endcase
		st_d = st_q;
		if (go) begin
			unique case (st_q)
				cts_pkg::B_IDLE: if (!q_empty) st_d = cts_pkg::B_SEP;
				cts_pkg::B_CONV: if (pos_q == 7'(cts_pkg::VALUE_BITS)) st_d = cts_pkg::B_TRIM;
				cts_pkg::B_TRIM: if (!trim_more) st_d = cts_pkg::B_SIGN;
				cts_pkg::B_DONE: st_d = cts_pkg::B_IDLE;
				default:         if (!emit_en) st_d = succ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < cts_pkg::BCD_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				(bcd_q[4*i +: 4] + 4'd3) : bcd_q[4*i +: 4];
		end
	end

	assign in_neg = (q_data.num != cts_pkg::NUM_UINT) && q_data.value_bits[63];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= cts_pkg::B_IDLE;
			pos_q    <= 7'd0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (go) begin
				if (st_d != st_q) begin
					pos_q <= 7'd0;
				end else if (emit_en || st_q == cts_pkg::B_CONV) begin
					pos_q <= pos_q + 7'd1;
				end
				if (emit_en) begin
					hold_v_q <= 1'b1;
				end else if (st_q == cts_pkg::B_DONE) begin
					hold_v_q <= 1'b0;
				end
			end
			if (push_out) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Number datapath: load, 64 shift-and-adjust steps, then leading-zero trim.
	always_ff @(posedge clk) begin
		if (go) begin
			unique case (st_q)
				cts_pkg::B_IDLE: begin
					if (!q_empty) begin
						job_q <= q_data;
						neg_q <= in_neg;
						mag_q <= in_neg ? (64'd0 - q_data.value_bits) : q_data.value_bits;
						bcd_q <= '0;
						len_q <= 5'(cts_pkg::BCD_DIGITS);
					end
				end
				cts_pkg::B_CONV: begin
					if (pos_q < 7'(cts_pkg::VALUE_BITS)) begin
						bcd_q <= {bcd_adj[78:0], mag_q[63]};
						mag_q <= {mag_q[62:0], 1'b0};
					end
				end
				cts_pkg::B_TRIM: begin
					if (trim_more) begin
						bcd_q <= {bcd_q[75:0], 4'h0};
						len_q <= len_q - 5'd1;
					end
				end
				cts_pkg::B_DIG1, cts_pkg::B_DIG2: begin
					if (emit_en) bcd_q <= {bcd_q[75:0], 4'h0};
				end
				default: ;
			endcase
			if (emit_en) begin
				hold_c_q <= ch;
			end
		end
		if (push_out) begin
			out_q.out_char  <= hold_c_q;
			out_q.last_char <= (st_q == cts_pkg::B_DONE);
		end
	end

	a_done_has_char: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == cts_pkg::B_DONE) |-> hold_v_q) else $error("transaction ended with no character");
	a_conv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == cts_pkg::B_CONV) |-> (pos_q <= 7'(cts_pkg::VALUE_BITS)))
		else $error("conversion ran past its bit count");
	a_push_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		push_out |-> out_free) else $error("output register overwritten");

endmodule

### sv/cpon_text_serializer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpon_text_serializer_top
// Text-notation serializer: one value item in, its characters out, one per
// result item, with a nesting stack for lists, maps, int-maps and meta.
// ----------------------------------------------------------------------------
//   channel   handshake          payload
//   input     push / full        item   (cts_pkg::in_item_t)
//   result    empty / pop        result (cts_pkg::out_item_t)
//   config    cfg_wen            cfg_wdata (depth_limit, 5 bits)
//
// The front end takes one item at a time and is full until done with it (an
// opener of a printed level adds a second level-memory write). The engine
// emits one character per cycle while the result side pops, plus sequencing
// per transaction; a number adds serial BCD conversion and a leading-zero
// trim. Reset is asynchronous and needs no clearing pass. A two-entry queue
// lets the front end run ahead while the result side is stalled.
// ----------------------------------------------------------------------------
module cpon_text_serializer_top #(
	parameter int MAX_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  cts_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output cts_pkg::out_item_t result,
	input  logic               cfg_wen,
	input  logic [4:0]         cfg_wdata
);

	logic          q_push, q_full, q_pop, q_empty;
	cts_pkg::job_t q_wdata, q_rdata;

	cts_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.q_push    (q_push),
		.q_data    (q_wdata),
		.q_full    (q_full)
	);

	cts_job_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	cts_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_data  (q_rdata),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
